// ----- hw/rtl/bad_pkg.sv -----
// Shared constants, types and helpers of the box-average downsampler.
`default_nettype none

package bad_pkg;

    localparam int MAX_OUT_WIDTH  = 1024;
    localparam int MAX_IN_SIDE    = 4096;
    localparam int MAX_BLOCK_SIDE = 16;

    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int TDATA_W = NUM_CH * CH_W;
    localparam int ADDR_W  = $clog2(MAX_OUT_WIDTH);
    localparam int OCOL_W  = ADDR_W + 1;
    localparam int IN_W    = $clog2(MAX_IN_SIDE) + 1;
    localparam int SUB_W   = $clog2(MAX_BLOCK_SIDE);
    localparam int BLK_W   = SUB_W + 1;
    localparam int AREA_W  = 2 * SUB_W + 1;
    localparam int SUM_W   = 2 * SUB_W + CH_W;
    localparam int WORD_W  = NUM_CH * SUM_W;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (word address paddr[4:2])
    localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_BLOCK_W    = 3'd4;
    localparam logic [2:0] REG_BLOCK_H    = 3'd5;

    typedef struct packed {
        logic [IN_W-1:0]   iw;
        logic [IN_W-1:0]   ih;
        logic [OCOL_W-1:0] ow;
        logic [IN_W-1:0]   oh;
        logic [BLK_W-1:0]  bw;
        logic [BLK_W-1:0]  bh;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              active;
        logic              first;
        logic              done;
        logic              fend;
    } pos_t;

    typedef struct packed {
        logic                         valid;
        logic [NUM_CH-1:0][SUM_W-1:0] sum;
        logic [AREA_W-1:0]            area;
        logic                         fend;
    } div_in_t;

    function automatic logic [IN_W-1:0] clamp_side(logic [12:0] v);
        logic [IN_W-1:0] r;
        if (v == 13'd0)
            r = IN_W'(1);
        else if (v > 13'(MAX_IN_SIDE))
            r = IN_W'(MAX_IN_SIDE);
        else
            r = IN_W'(v);
        return r;
    endfunction

    function automatic logic [OCOL_W-1:0] clamp_ow(logic [10:0] v);
        logic [OCOL_W-1:0] r;
        if (v == 11'd0)
            r = OCOL_W'(1);
        else if (v > 11'(MAX_OUT_WIDTH))
            r = OCOL_W'(MAX_OUT_WIDTH);
        else
            r = OCOL_W'(v);
        return r;
    endfunction

    function automatic logic [BLK_W-1:0] clamp_blk(logic [4:0] v);
        logic [BLK_W-1:0] r;
        if (v == 5'd0)
            r = BLK_W'(1);
        else if (v > 5'(MAX_BLOCK_SIDE))
            r = BLK_W'(MAX_BLOCK_SIDE);
        else
            r = BLK_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bad_ram.sv -----
// Generic simple dual-port RAM with registered read, old data on collision.
`default_nettype none

module bad_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bad_seq.sv -----
// Raster position counters: input, sub-block and output column/row tracking.
`default_nettype none

module bad_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bad_pkg::cfg_t cfg,
    input  wire logic          step,
    output bad_pkg::pos_t      pos
);

    import bad_pkg::*;

    logic [IN_W-2:0]   in_col_reg, in_col_next;
    logic [IN_W-2:0]   in_row_reg, in_row_next;
    logic [SUB_W-1:0]  sub_col_reg, sub_col_next;
    logic [SUB_W-1:0]  sub_row_reg, sub_row_next;
    logic [OCOL_W-1:0] out_col_reg, out_col_next;
    logic [IN_W-1:0]   out_row_reg, out_row_next;

    logic col_wrap, row_wrap, subc_wrap, subr_wrap;

    assign col_wrap  = {1'b0, in_col_reg} >= (cfg.iw - IN_W'(1));
    assign row_wrap  = {1'b0, in_row_reg} >= (cfg.ih - IN_W'(1));
    assign subc_wrap = {1'b0, sub_col_reg} >= (cfg.bw - BLK_W'(1));
    assign subr_wrap = {1'b0, sub_row_reg} >= (cfg.bh - BLK_W'(1));

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (col_wrap)
        begin
            in_col_next  = '0;
            sub_col_next = '0;
            out_col_next = '0;
            if (row_wrap)
            begin
                in_row_next  = '0;
                sub_row_next = '0;
                out_row_next = '0;
            end
            else
            begin
                in_row_next = in_row_reg + 1'b1;
                if (subr_wrap)
                begin
                    sub_row_next = '0;
                    if (out_row_reg < IN_W'(MAX_IN_SIDE))
                    begin
                        out_row_next = out_row_reg + 1'b1;
                    end
                end
                else
                begin
                    sub_row_next = sub_row_reg + 1'b1;
                end
            end
        end
        else
        begin
            in_col_next = in_col_reg + 1'b1;
            if (subc_wrap)
            begin
                sub_col_next = '0;
                if (out_col_reg < OCOL_W'(MAX_OUT_WIDTH))
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
            else
            begin
                sub_col_next = sub_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (step)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign pos.addr   = out_col_reg[ADDR_W-1:0];
    assign pos.active = (out_col_reg < cfg.ow) && (out_row_reg < cfg.oh);
    assign pos.first  = (sub_row_reg == '0) && (sub_col_reg == '0);
    assign pos.done   = subc_wrap && subr_wrap;
    assign pos.fend   = (out_col_reg == (cfg.ow - OCOL_W'(1)))
                     && (out_row_reg == (cfg.oh - IN_W'(1)));

endmodule

`default_nettype wire

// ----- hw/rtl/bad_div.sv -----
// Pipelined restoring divider: block sums by block area, one quotient bit per stage.
`default_nettype none

module bad_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire bad_pkg::div_in_t din,
    output logic                  out_valid,
    output logic [bad_pkg::NUM_CH-1:0][bad_pkg::CH_W-1:0] out_avg,
    output logic                  out_fend
);

    import bad_pkg::*;

    localparam int NSTG = CH_W;

    typedef struct packed {
        logic [NUM_CH-1:0]            sat;
        logic [NUM_CH-1:0][SUM_W-1:0] rem;
        logic [NUM_CH-1:0][CH_W-1:0]  q;
        logic [AREA_W-1:0]            area;
        logic                         fend;
    } dstage_t;

    function automatic dstage_t div_step(dstage_t s, logic [$clog2(NSTG)-1:0] k);
        dstage_t        r;
        logic [SUM_W:0] dv;
        r  = s;
        dv = (SUM_W + 1)'(s.area) << k;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if ({1'b0, s.rem[c]} >= dv)
            begin
                r.rem[c]  = s.rem[c] - dv[SUM_W-1:0];
                r.q[c][k] = 1'b1;
            end
        end
        return r;
    endfunction

    dstage_t         st_reg [NSTG];
    dstage_t         st_next [NSTG];
    logic [NSTG-1:0] st_valid_reg;
    dstage_t         entry;

    // Quotient of 256 or more saturates; otherwise 8 bits suffice.
    always_comb
    begin
        entry.rem  = din.sum;
        entry.q    = '0;
        entry.area = din.area;
        entry.fend = din.fend;
        for (int c = 0; c < NUM_CH; c++)
        begin
            entry.sat[c] = {1'b0, din.sum[c]} >= ((SUM_W + 1)'(din.area) << CH_W);
        end
    end

    always_comb
    begin
        st_next[0] = div_step(entry, ($clog2(NSTG))'(NSTG - 1));
        for (int s = 1; s < NSTG; s++)
        begin
            st_next[s] = div_step(st_reg[s-1], ($clog2(NSTG))'(NSTG - 1 - s));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= '0;
        end
        else if (adv)
        begin
            st_valid_reg <= {st_valid_reg[NSTG-2:0], din.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_valid = st_valid_reg[NSTG-1];
    assign out_fend  = st_reg[NSTG-1].fend;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            out_avg[c] = st_reg[NSTG-1].sat[c] ? {CH_W{1'b1}} : st_reg[NSTG-1].q[c];
        end
    end

    // A finished, unsaturated division leaves a remainder below the divisor
    a_rem_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !st_reg[NSTG-1].sat[0]
            |-> st_reg[NSTG-1].rem[0] < SUM_W'(st_reg[NSTG-1].area))
        else $error("red remainder not below area");

    a_rem_blue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !st_reg[NSTG-1].sat[2]
            |-> st_reg[NSTG-1].rem[2] < SUM_W'(st_reg[NSTG-1].area))
        else $error("blue remainder not below area");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !adv |=> out_valid && $stable(out_avg))
        else $error("divider result lost during stall");

endmodule

`default_nettype wire

// ----- hw/rtl/box_average_downsampler.sv -----
// Top level of the box-average downsampler: register port, sum RAM update and output stage.
// A result passes the read-modify-write stage, divider stages and output register to m_tvalid.
// Throughput: one pixel per cycle unless stalled; the column-sum RAM is read at acceptance
// and written back by the next stage, forwarded when consecutive pixels hit the same column.
// The pipeline stalls only while a result waits on m_tready and another one is ready.
// Reset clears counters and pipeline valids and sets all size registers to 1;
// the sum RAM is not cleared (the first pixel of each block overwrites its entry).
`default_nettype none

module box_average_downsampler (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bad_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [bad_pkg::PDATA_W-1:0]     pwdata,
    output logic      [bad_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bad_pkg::TDATA_W-1:0]     s_tdata,  // red, green, blue
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [bad_pkg::TDATA_W-1:0]     m_tdata,  // avg_red, avg_green, avg_blue
    output logic                                 m_tlast   // frame_end
);

    import bad_pkg::*;

    // Configuration registers
    logic [12:0] in_width_reg, in_height_reg, out_height_reg;
    logic [10:0] out_width_reg;
    logic [4:0]  block_w_reg, block_h_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;
    cfg_t        cfg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= 13'd1;
            in_height_reg  <= 13'd1;
            out_width_reg  <= 11'd1;
            out_height_reg <= 13'd1;
            block_w_reg    <= 5'd1;
            block_h_reg    <= 5'd1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_IN_WIDTH:   in_width_reg   <= pwdata[12:0];
                REG_IN_HEIGHT:  in_height_reg  <= pwdata[12:0];
                REG_OUT_WIDTH:  out_width_reg  <= pwdata[10:0];
                REG_OUT_HEIGHT: out_height_reg <= pwdata[12:0];
                REG_BLOCK_W:    block_w_reg    <= pwdata[4:0];
                REG_BLOCK_H:    block_h_reg    <= pwdata[4:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IN_WIDTH:   prdata = PDATA_W'(in_width_reg);
            REG_IN_HEIGHT:  prdata = PDATA_W'(in_height_reg);
            REG_OUT_WIDTH:  prdata = PDATA_W'(out_width_reg);
            REG_OUT_HEIGHT: prdata = PDATA_W'(out_height_reg);
            REG_BLOCK_W:    prdata = PDATA_W'(block_w_reg);
            REG_BLOCK_H:    prdata = PDATA_W'(block_h_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.iw = clamp_side(in_width_reg);
    assign cfg.ih = clamp_side(in_height_reg);
    assign cfg.ow = clamp_ow(out_width_reg);
    assign cfg.oh = clamp_side(out_height_reg);
    assign cfg.bw = clamp_blk(block_w_reg);
    assign cfg.bh = clamp_blk(block_h_reg);

    // Pipeline control
    logic adv, acc;
    logic div_out_valid;
    logic [NUM_CH-1:0][CH_W-1:0] div_avg;
    logic div_fend;

    assign adv      = !(m_tvalid && !m_tready && div_out_valid);
    assign s_tready = adv;
    assign acc      = s_tvalid && s_tready;

    pos_t pos;

    bad_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (acc),
        .pos   (pos)
    );

    logic [2*BLK_W-1:0] area_full;
    assign area_full = cfg.bw * cfg.bh;

    // Read-modify-write stage
    logic                         b_valid_reg;
    logic [ADDR_W-1:0]            b_addr_reg;
    logic [NUM_CH-1:0][CH_W-1:0]  b_px_reg;
    logic                         b_first_reg, b_done_reg, b_fend_reg, b_fwd_reg;
    logic [AREA_W-1:0]            b_area_reg;
    logic [NUM_CH-1:0][SUM_W-1:0] b_fwd_data_reg;

    logic                         ram_re, ram_we;
    logic [WORD_W-1:0]            ram_rdata;
    logic [NUM_CH-1:0][SUM_W-1:0] b_base, b_sum;
    logic [NUM_CH-1:0][SUM_W:0]   b_wide;
    div_in_t                      div_in;

    assign ram_re = acc && pos.active;
    assign ram_we = b_valid_reg && adv;

    bad_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_addr_reg),
        .wdata (b_sum),
        .re    (ram_re),
        .raddr (pos.addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        b_base = b_fwd_reg ? b_fwd_data_reg : ram_rdata;
        for (int c = 0; c < NUM_CH; c++)
        begin
            b_wide[c] = {1'b0, b_base[c]} + (SUM_W + 1)'(b_px_reg[c]);
            b_sum[c]  = b_first_reg ? SUM_W'(b_px_reg[c]) : b_wide[c][SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= ram_re;
        end
    end

    // The RAM returns old data when the write-back hits the address read in the same cycle
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            b_addr_reg     <= pos.addr;
            b_px_reg       <= s_tdata;
            b_first_reg    <= pos.first;
            b_done_reg     <= pos.done;
            b_fend_reg     <= pos.fend;
            b_area_reg     <= area_full[AREA_W-1:0];
            b_fwd_reg      <= ram_we && (b_addr_reg == pos.addr);
            b_fwd_data_reg <= b_sum;
        end
    end

    assign div_in.valid = b_valid_reg && b_done_reg;
    assign div_in.sum   = b_sum;
    assign div_in.area  = b_area_reg;
    assign div_in.fend  = b_fend_reg;

    bad_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .din       (div_in),
        .out_valid (div_out_valid),
        .out_avg   (div_avg),
        .out_fend  (div_fend)
    );

    // Output register
    logic                m_valid_reg;
    logic [TDATA_W-1:0]  m_data_reg;
    logic                m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (adv && div_out_valid)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && div_out_valid)
        begin
            m_data_reg <= div_avg;
            m_last_reg <= div_fend;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Accumulated sums stay inside the sum width
    a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && !b_first_reg
            |-> !b_wide[0][SUM_W] && !b_wide[1][SUM_W] && !b_wide[2][SUM_W])
        else $error("column sum overflow");

    a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !adv |=> b_valid_reg && $stable(b_addr_reg) && $stable(b_sum))
        else $error("write-back stage changed during stall");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> m_tvalid && div_out_valid)
        else $error("pipeline stalled without a waiting result");

endmodule

`default_nettype wire

// ----- test/box_average_checker.sv -----
// Checker for the box-average downsampler: predicts averaged pixels and compares them.
`default_nettype none

module box_average_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bad_pkg::PADDR_W-1:0] paddr,
    input  wire logic [bad_pkg::PDATA_W-1:0] pwdata,
    input  wire logic [bad_pkg::PDATA_W-1:0] prdata,
    input  wire logic                        pready,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [bad_pkg::TDATA_W-1:0] s_tdata,  // red, green, blue
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [bad_pkg::TDATA_W-1:0] m_tdata,  // avg_red, avg_green, avg_blue
    input  wire logic                        m_tlast,  // frame_end
    output int                               fail_count,
    output int                               pending
);
    import bad_pkg::*;

    typedef struct packed {
        logic              frame_end;
        logic [CH_W-1:0]   avg_blue;
        logic [CH_W-1:0]   avg_green;
        logic [CH_W-1:0]   avg_red;
    } avg_pixel_t;

    localparam int MAX_REPORTS = 100;

    avg_pixel_t  averages_due [$];
    string       chan_name [NUM_CH];

    logic [12:0] in_width_r;
    logic [12:0] in_height_r;
    logic [10:0] out_width_r;
    logic [12:0] out_height_r;
    logic [4:0]  block_w_r;
    logic [4:0]  block_h_r;

    int unsigned column_sums [MAX_OUT_WIDTH][NUM_CH];
    int unsigned in_col, in_row, sub_col, sub_row, out_col, out_row;

    initial
    begin
        fail_count = 0;
        chan_name = '{"avg_red", "avg_green", "avg_blue"};
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int unsigned fit(int unsigned v, int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [PDATA_W-1:0] stored_register(logic [2:0] idx);
        case (idx)
            REG_IN_WIDTH:   return PDATA_W'(in_width_r);
            REG_IN_HEIGHT:  return PDATA_W'(in_height_r);
            REG_OUT_WIDTH:  return PDATA_W'(out_width_r);
            REG_OUT_HEIGHT: return PDATA_W'(out_height_r);
            REG_BLOCK_W:    return PDATA_W'(block_w_r);
            REG_BLOCK_H:    return PDATA_W'(block_h_r);
            default:        return prdata;
        endcase
    endfunction

    // For a pixel inside the output area, accumulate it into its column entry and queue
    // an average when a block completes; then advance the raster counters.
    function automatic void take_pixel(logic [TDATA_W-1:0] px);
        int unsigned iw, ih, ow, oh, bw, bh, area, mean;
        avg_pixel_t  avg;
        iw = fit(in_width_r, MAX_IN_SIDE);
        ih = fit(in_height_r, MAX_IN_SIDE);
        ow = fit(out_width_r, MAX_OUT_WIDTH);
        oh = fit(out_height_r, MAX_IN_SIDE);
        bw = fit(block_w_r, MAX_BLOCK_SIDE);
        bh = fit(block_h_r, MAX_BLOCK_SIDE);
        if (out_col < ow && out_row < oh)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (sub_row == 0 && sub_col == 0)
                    column_sums[out_col][c] = px[c*CH_W +: CH_W];
                else
                    column_sums[out_col][c] =
                        (column_sums[out_col][c] + px[c*CH_W +: CH_W]) & 32'hFF_FFFF;
            end
            if (sub_col >= bw - 1 && sub_row >= bh - 1)
            begin
                area = bw * bh;
                avg = '0;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    mean = column_sums[out_col][c] / area;
                    avg[c*CH_W +: CH_W] = (mean > 255) ? 8'hFF : 8'(mean);
                end
                avg.frame_end = (out_col == ow - 1 && out_row == oh - 1);
                averages_due.push_back(avg);
            end
        end

        if (in_col >= iw - 1)
        begin
            in_col = 0;
            sub_col = 0;
            out_col = 0;
            if (in_row >= ih - 1)
            begin
                in_row = 0;
                sub_row = 0;
                out_row = 0;
            end
            else
            begin
                in_row++;
                if (sub_row >= bh - 1)
                begin
                    sub_row = 0;
                    if (out_row < MAX_IN_SIDE)
                        out_row++;
                end
                else
                    sub_row++;
            end
        end
        else
        begin
            in_col++;
            if (sub_col >= bw - 1)
            begin
                sub_col = 0;
                if (out_col < MAX_OUT_WIDTH)
                    out_col++;
            end
            else
                sub_col++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_pixel_t want;
        if (!rst_n)
        begin
            in_width_r   = 13'd1;
            in_height_r  = 13'd1;
            out_width_r  = 11'd1;
            out_height_r = 13'd1;
            block_w_r    = 5'd1;
            block_h_r    = 5'd1;
            in_col  = 0;
            in_row  = 0;
            sub_col = 0;
            sub_row = 0;
            out_col = 0;
            out_row = 0;
            averages_due.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[4:2])
                        REG_IN_WIDTH:   in_width_r   = pwdata[12:0];
                        REG_IN_HEIGHT:  in_height_r  = pwdata[12:0];
                        REG_OUT_WIDTH:  out_width_r  = pwdata[10:0];
                        REG_OUT_HEIGHT: out_height_r = pwdata[12:0];
                        REG_BLOCK_W:    block_w_r    = pwdata[4:0];
                        REG_BLOCK_H:    block_h_r    = pwdata[4:0];
                        default: ;
                    endcase
                end
                else if (prdata !== stored_register(paddr[4:2]))
                    report_mismatch($sformatf("register read at 0x%0h: got 0x%0h, want 0x%0h",
                                              paddr, prdata, stored_register(paddr[4:2])));
            end

            // Outputs first: a result never belongs to a pixel taken at the same edge.
            if (m_tvalid && m_tready)
            begin
                if (averages_due.size() == 0)
                    report_mismatch($sformatf("unexpected output transfer 0x%0h last=%b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = averages_due.pop_front();
                    for (int c = 0; c < NUM_CH; c++)
                        if (m_tdata[c*CH_W +: CH_W] !== want[c*CH_W +: CH_W])
                            report_mismatch($sformatf("%s: got %0d, want %0d", chan_name[c],
                                                      m_tdata[c*CH_W +: CH_W],
                                                      want[c*CH_W +: CH_W]));
                    if (m_tlast !== want.frame_end)
                        report_mismatch($sformatf("frame_end: got %b, want %b",
                                                  m_tlast, want.frame_end));
                end
            end

            if (s_tvalid && s_tready)
                take_pixel(s_tdata);

            pending <= averages_due.size();
        end
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Top of the downsampler testbench: clock, reset, register setup, pixel stimulus and verdict.
`default_nettype none

module testbench;
    import bad_pkg::*;

    localparam int RANDOM_PIXELS  = 1100;
    localparam int CALM_PIXELS    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;

    int                  fail_count;
    int                  pending;
    int unsigned         quiet_cycles = 0;
    int unsigned         frame_px;
    bit                  sender_idles = 1'b1;
    bit                  reader_idles = 1'b1;
    bit                  hold_request = 1'b0;
    bit                  hold_served  = 1'b0;
    logic [TDATA_W-1:0]  trunc_frame [8];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    box_average_downsampler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    box_average_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // End the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        wait (rst_n);
        forever
        begin
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (reader_idles && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic int unsigned fit_side(logic [12:0] v);
        return (v == 0) ? 1 : ((v > MAX_IN_SIDE) ? MAX_IN_SIDE : v);
    endfunction

    function automatic logic [PDATA_W-1:0] noisy(int unsigned v, int width);
        return ($urandom_range(0, 3) == 0) ? (v | ($urandom << width)) : v;
    endfunction

    function automatic logic [TDATA_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return TDATA_W'($urandom);
        endcase
    endfunction

    task automatic apb_access(input logic write, input logic [2:0] idx,
                              input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(input logic [TDATA_W-1:0] px);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_pixel(random_pixel());
        s_tvalid <= 1'b0;
    endtask

    // Wait for every expected average, then let pixels that give none drain.
    task automatic settle();
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [PDATA_W-1:0] iw, ih, ow, oh, bw, bh);
        settle();
        apb_access(1'b1, REG_IN_WIDTH,   iw);
        apb_access(1'b1, REG_IN_HEIGHT,  ih);
        apb_access(1'b1, REG_OUT_WIDTH,  ow);
        apb_access(1'b1, REG_OUT_HEIGHT, oh);
        apb_access(1'b1, REG_BLOCK_W,    bw);
        apb_access(1'b1, REG_BLOCK_H,    bh);
        for (int r = REG_IN_WIDTH; r <= REG_BLOCK_H; r++)
            apb_access(1'b0, 3'(r), '0);
        frame_px = fit_side(iw[12:0]) * fit_side(ih[12:0]);
    endtask

    initial
    begin
        int unsigned random_fed;
        int unsigned bw, bh, ow, oh, iw, ih, frames;

        trunc_frame = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h010101,
                        24'hFFFFFF, 24'hFEFEFE, 24'h000000, 24'h020202};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: every pixel is a whole frame.
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h5AA5C3);
        send_pixel(24'hA55A3C);
        s_tvalid <= 1'b0;

        // Two 2x2 blocks: truncating mean, frame end on the second.
        configure(4, 2, 2, 1, 2, 2);
        foreach (trunc_frame[k])
            send_pixel(trunc_frame[k]);
        s_tvalid <= 1'b0;

        // Zero sizes act as one.
        configure(0, 0, 0, 0, 0, 0);
        send_random(2);

        // Blocks cut off at the row end and the frame end.
        configure(3, 3, 2, 2, 2, 2);
        send_random(frame_px);

        // Pixels beyond the covered area are dropped.
        configure(3, 1, 1, 1, 2, 1);
        send_random(frame_px);

        // Oversized registers saturate; run part of a row, then shrink the frame.
        configure(8191, 1, 2047, 8191, 0, 0);
        send_random(40);
        // Counters past the new, smaller bounds wrap at the next pixel.
        configure(1, 1, 1, 1, 1, 1);
        send_random(1);
        configure(16, 16, 1, 1, 31, 16);
        send_random(frame_px);

        // Long output hold-off with a steady input: the block must stall its input.
        configure(16, 16, 16, 16, 1, 1);
        sender_idles = 1'b0;
        hold_request = 1'b1;
        send_random(frame_px);

        random_fed = 0;
        while (random_fed < RANDOM_PIXELS)
        begin
            bw = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
            bh = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
            ow = (bw > 3) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            oh = (bh > 3) ? $urandom_range(1, 2) : $urandom_range(1, 4);
            // Last block column or row may be short, exact, or followed by spare pixels.
            iw = (ow - 1) * bw + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * bw) : bw);
            ih = (oh - 1) * bh + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * bh) : bh);
            configure(noisy(iw, 13), noisy(ih, 13), noisy(ow, 11), noisy(oh, 13),
                      noisy(bw, 5), noisy(bh, 5));
            if (random_fed + CALM_PIXELS >= RANDOM_PIXELS)
            begin
                sender_idles = 1'b0;
                reader_idles = 1'b0;
            end
            else
            begin
                sender_idles = ($urandom_range(0, 3) != 0);
                reader_idles = ($urandom_range(0, 3) != 0);
            end
            // Keep large frames to a single pass.
            frames = (frame_px > 150) ? 1 : $urandom_range(1, 3);
            send_random(frames * frame_px);
            random_fed += frames * frame_px;
        end

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ----- box_average_downsampler.f -----
hw/rtl/bad_pkg.sv
hw/rtl/bad_ram.sv
hw/rtl/bad_seq.sv
hw/rtl/bad_div.sv
hw/rtl/box_average_downsampler.sv
test/box_average_checker.sv
test/testbench.sv
